[sv/lle_pkg.sv]
// ----------------------------------------------------------------------------
// lle_pkg
// types and constants shared by the linked list engine
// ----------------------------------------------------------------------------
package lle_pkg;

  localparam int Capacity   = 256;
  localparam int IdxW       = $clog2(Capacity);
  localparam int LinkW      = IdxW + 1;
  localparam int ValueWidth = 32;

  localparam logic [LinkW-1:0] NIL = LinkW'(Capacity);

  localparam logic [3:0] REQ_INS_START  = 4'd0;
  localparam logic [3:0] REQ_INS_END    = 4'd1;
  localparam logic [3:0] REQ_INS_AFTER  = 4'd2;
  localparam logic [3:0] REQ_INS_BEFORE = 4'd3;
  localparam logic [3:0] REQ_GET_START  = 4'd4;
  localparam logic [3:0] REQ_GET_END    = 4'd5;
  localparam logic [3:0] REQ_POP_START  = 4'd6;
  localparam logic [3:0] REQ_POP_END    = 4'd7;
  localparam logic [3:0] REQ_RM_START   = 4'd8;
  localparam logic [3:0] REQ_RM_END     = 4'd9;
  localparam logic [3:0] REQ_RM_KEY     = 4'd10;
  localparam logic [3:0] REQ_FIND       = 4'd11;
  localparam logic [3:0] REQ_SIZE       = 4'd12;
  localparam logic [3:0] REQ_EMPTY      = 4'd13;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic               found;
    logic [8:0]         count;
  } rsp_t;

endpackage

[sv/linked_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// linked_list_engine_unit
// bounded doubly linked list of signed values held in on-chip memory
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_ready/req) carries one command per transfer;
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per
//   command, in command order.
// sequencing:
//   size, empty, unused codes, end operations on an empty list and end
//   inserts into a full store go from decode straight to done. get at an
//   end adds a read of the target slot. pop or remove at an end and insert
//   at an end also update links; an insert whose new slot comes off the
//   free list adds one read of its link. key commands walk at most count
//   slots, each with one read issue and one compare.
// throughput:
//   one command at a time; the next command is taken as soon as the result
//   sits in the output register, even while the receiver stalls it.
// reset:
//   rst clears the list heads, free list, fill mark and count. the slot
//   memories are not cleared; a slot is only ever read after being written.
// stall:
//   a held result blocks only the launch of the following command's result;
//   the engine waits in its done state until the output register is free.
// ----------------------------------------------------------------------------
module linked_list_engine_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lle_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lle_pkg::rsp_t rsp
);

  localparam int IW = lle_pkg::IdxW;
  localparam int LW = lle_pkg::LinkW;

  // state codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_SRD    = 4'd2;  // search: issue read of cur
  localparam logic [3:0] S_SCMP   = 4'd3;  // search: compare read data
  localparam logic [3:0] S_INS    = 4'd4;  // write new slot value and links
  localparam logic [3:0] S_RDE    = 4'd5;  // read target links
  localparam logic [3:0] S_RDEW   = 4'd6;  // target data ready
  localparam logic [3:0] S_UNL    = 4'd7;  // fix neighbors on unlink
  localparam logic [3:0] S_FRW    = 4'd8;  // free-list read wait
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_UNL2   = 4'd10;

  // slot memories
  logic [lle_pkg::ValueWidth-1:0] val_mem [lle_pkg::Capacity];
  logic [LW-1:0] nxt_mem [lle_pkg::Capacity];
  logic [LW-1:0] prv_mem [lle_pkg::Capacity];

  logic [IW-1:0] rd_addr;
  logic          rd_en;
  logic [lle_pkg::ValueWidth-1:0] rd_val;
  logic [LW-1:0] rd_nxt, rd_prv;

  // write ports: value, next, prev each with own address
  logic          wv_en, wn_en, wp_en;
  logic [IW-1:0] wv_addr, wn_addr, wp_addr;
  logic [lle_pkg::ValueWidth-1:0] wv_data;
  logic [LW-1:0] wn_data, wp_data;

  always_ff @(posedge clk) begin
    if (wv_en) val_mem[wv_addr] <= wv_data;
    if (wn_en) nxt_mem[wn_addr] <= wn_data;
    if (wp_en) prv_mem[wp_addr] <= wp_data;
    if (rd_en) begin
      rd_val <= val_mem[rd_addr];
      rd_nxt <= nxt_mem[rd_addr];
      rd_prv <= prv_mem[rd_addr];
    end
  end

  // control registers
  logic [3:0]  state, state_next;
  lle_pkg::req_t cmd;
  logic [LW-1:0] first_index, last_index, free_head, fill_mark;
  logic [8:0]    entry_count, steps;
  logic [LW-1:0] cur, tgt, slot;
  logic [1:0]    st;
  logic          fnd;
  logic [31:0]   data;

  // free-list push needs its own next write; it is done in the done state that follows
  logic push_pend;
  logic [LW-1:0] push_slot, push_link;

  // output register
  logic out_free;
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  wire is_insert = (cmd.req_type == lle_pkg::REQ_INS_START) ||
                   (cmd.req_type == lle_pkg::REQ_INS_END) ||
                   (cmd.req_type == lle_pkg::REQ_INS_AFTER) ||
                   (cmd.req_type == lle_pkg::REQ_INS_BEFORE);
  wire need_search = (cmd.req_type == lle_pkg::REQ_INS_AFTER) ||
                     (cmd.req_type == lle_pkg::REQ_INS_BEFORE) ||
                     (cmd.req_type == lle_pkg::REQ_RM_KEY) ||
                     (cmd.req_type == lle_pkg::REQ_FIND);
  wire is_end_op = (cmd.req_type >= lle_pkg::REQ_GET_START) &&
                   (cmd.req_type <= lle_pkg::REQ_RM_END);

  // slot allocation seen from current state
  wire from_free  = (free_head != lle_pkg::NIL);
  wire have_slot  = from_free || (fill_mark != lle_pkg::NIL);

  // neighbors of the new slot
  logic [LW-1:0] ins_p, ins_n;
  always_comb begin
    unique case (cmd.req_type)
      lle_pkg::REQ_INS_START:  begin ins_p = lle_pkg::NIL; ins_n = first_index; end
      lle_pkg::REQ_INS_END:    begin ins_p = last_index;   ins_n = lle_pkg::NIL; end
      lle_pkg::REQ_INS_AFTER:  begin ins_p = tgt;          ins_n = rd_nxt;       end
      default:                 begin ins_p = rd_prv;       ins_n = tgt;          end
    endcase
  end

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = '0;
    wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
    wv_addr = slot[IW-1:0]; wn_addr = '0; wp_addr = '0;
    wv_data = cmd.value; wn_data = '0; wp_data = '0;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_DEC;
      S_DEC: begin
        if (need_search) begin
          state_next = S_SRD;
        end else if (is_insert) begin
          if (!have_slot) state_next = S_DONE;
          else if (from_free) begin
            rd_en = 1'b1; rd_addr = free_head[IW-1:0]; state_next = S_FRW;
          end else state_next = S_INS;
        end else if (is_end_op) begin
          if (entry_count == 9'd0 || tgt == lle_pkg::NIL) state_next = S_DONE;
          else begin
            rd_en = 1'b1; rd_addr = tgt[IW-1:0]; state_next = S_RDEW;
          end
        end else state_next = S_DONE;
      end
      S_SRD: begin
        if (steps == entry_count || cur == lle_pkg::NIL) state_next = S_DONE;
        else begin
          rd_en = 1'b1; rd_addr = cur[IW-1:0]; state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (rd_val == cmd.key) begin
          if (cmd.req_type == lle_pkg::REQ_FIND) state_next = S_DONE;
          else if (cmd.req_type == lle_pkg::REQ_RM_KEY) state_next = S_UNL;
          else if (!have_slot) state_next = S_DONE;
          else if (from_free) begin
            rd_en = 1'b1; rd_addr = free_head[IW-1:0]; state_next = S_FRW;
          end else state_next = S_RDE;
        end else state_next = S_SRD;
      end
      S_FRW: state_next = (cmd.req_type == lle_pkg::REQ_INS_AFTER ||
                           cmd.req_type == lle_pkg::REQ_INS_BEFORE) ? S_RDE : S_INS;
      S_RDE: begin
        rd_en = 1'b1; rd_addr = tgt[IW-1:0]; state_next = S_INS;
      end
      S_INS: begin
        wv_en = 1'b1;
        wn_en = 1'b1; wn_addr = slot[IW-1:0]; wn_data = ins_n;
        wp_en = 1'b1; wp_addr = slot[IW-1:0]; wp_data = ins_p;
        state_next = S_UNL2;
      end
      S_UNL2: begin
        // insert: second half, fix neighbor links (ins_p/ins_n held in cur/tgt)
        state_next = S_DONE;
      end
      S_RDEW: begin
        if (cmd.req_type >= lle_pkg::REQ_POP_START) state_next = S_UNL;
        else state_next = S_DONE;
      end
      S_UNL: begin
        // rd_* holds target's links
        if (rd_prv != lle_pkg::NIL) begin
          wn_en = 1'b1; wn_addr = rd_prv[IW-1:0]; wn_data = rd_nxt;
        end
        if (rd_nxt != lle_pkg::NIL) begin
          wp_en = 1'b1; wp_addr = rd_nxt[IW-1:0]; wp_data = rd_prv;
        end
        state_next = S_DONE;
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // insert neighbor fix in the cycle after the slot write
    if (state == S_UNL2) begin
      if (cur != lle_pkg::NIL) begin
        wn_en = 1'b1; wn_addr = cur[IW-1:0]; wn_data = slot;
      end
      if (tgt != lle_pkg::NIL) begin
        wp_en = 1'b1; wp_addr = tgt[IW-1:0]; wp_data = slot;
      end
    end
    // freed slot goes onto the free list in the done step of an unlink
    if (state == S_UNL) begin
      wv_en = 1'b0;
    end
    if (push_pend) begin
      wn_en = 1'b1; wn_addr = push_slot[IW-1:0]; wn_data = push_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      first_index <= lle_pkg::NIL;
      last_index  <= lle_pkg::NIL;
      free_head   <= lle_pkg::NIL;
      fill_mark   <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
      push_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req_valid) begin
          cmd <= req;
          st <= lle_pkg::ST_OK; fnd <= 1'b0; data <= '0;
          steps <= '0;
          cur <= first_index;
          tgt <= req.req_type[0] ? last_index : first_index;
        end
        S_DEC: begin
          if (need_search) cur <= first_index;
          else if (is_insert && !have_slot) st <= lle_pkg::ST_FULL;
          else if (is_insert && !from_free) begin
            slot <= fill_mark; fill_mark <= fill_mark + 1'b1;
          end else if (is_insert) slot <= free_head;
          else if (is_end_op && (entry_count == 9'd0 || tgt == lle_pkg::NIL))
            st <= lle_pkg::ST_EMPTY;
          else if (cmd.req_type == lle_pkg::REQ_EMPTY)
            fnd <= (entry_count == 9'd0);
        end
        S_SRD: if (steps == entry_count || cur == lle_pkg::NIL) begin
          if (cmd.req_type != lle_pkg::REQ_FIND) st <= lle_pkg::ST_NOT_FOUND;
        end
        S_SCMP: begin
          steps <= steps + 1'b1;
          if (rd_val == cmd.key) begin
            tgt <= cur;
            if (cmd.req_type == lle_pkg::REQ_FIND) fnd <= 1'b1;
            else if (cmd.req_type != lle_pkg::REQ_RM_KEY) begin
              if (!have_slot) st <= lle_pkg::ST_FULL;
              else if (!from_free) begin
                slot <= fill_mark; fill_mark <= fill_mark + 1'b1;
              end else slot <= free_head;
            end
          end else cur <= rd_nxt;
        end
        S_FRW: free_head <= rd_nxt;
        S_INS: begin
          // keep neighbors for the link fix
          cur <= ins_p; tgt <= ins_n;
          if (ins_p == lle_pkg::NIL) first_index <= slot;
          if (ins_n == lle_pkg::NIL) last_index  <= slot;
          entry_count <= entry_count + 1'b1;
        end
        S_RDEW: if (cmd.req_type <= lle_pkg::REQ_POP_END) data <= rd_val;
        S_UNL: begin
          if (rd_prv == lle_pkg::NIL) first_index <= rd_nxt;
          if (rd_nxt == lle_pkg::NIL) last_index  <= rd_prv;
          if (entry_count != 9'd0) entry_count <= entry_count - 1'b1;
          push_pend <= 1'b1; push_slot <= tgt; push_link <= free_head;
          free_head <= tgt;
        end
        S_DONE: if (out_free) begin
          rsp.status    <= st;
          rsp.data_out  <= data;
          rsp.found     <= fnd;
          rsp.count     <= entry_count;
        end
        default: ;
      endcase
      if (push_pend) push_pend <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 9'(lle_pkg::Capacity))
    else $error("count above capacity");
  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> rsp_valid)
    else $error("result not launched");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (state == S_IDLE))
    else $error("ready outside idle");
  a_empty_heads: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && entry_count == 9'd0) |-> (first_index == lle_pkg::NIL))
    else $error("empty list with head");
`endif

endmodule
